/* hw/rtl/ud64_pkg.sv */
// shared constants and types for the unsigned divider
`default_nettype none

package ud64_pkg;

    // operand and quotient width used by the datapath, 8..64
    localparam int DATA_WIDTH = 64;

    // fixed width of every field on the item ports
    localparam int FIELD_W = 64;

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    // controller state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
    } row_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/ud64_cell.sv */
// one bit slice of the divider: remainder, dividend/quotient and divisor bits
`default_nettype none

module ud64_cell
    import ud64_pkg::*;
(
    input  wire logic      aclk,
    input  wire row_ctrl_t ctrl,
    input  wire logic      num_bit,
    input  wire logic      den_bit,
    input  wire logic      rem_in,
    input  wire logic      quo_in,
    input  wire logic      borrow_in,
    input  wire logic      take,
    output logic           rem_out,
    output logic           quo_out,
    output logic           borrow_out
);

    logic rem_reg;
    logic quo_reg;
    logic den_reg;
    logic diff;

    // trial subtract of the divisor bit from the shifted remainder bit
    assign diff       = rem_in ^ den_reg ^ borrow_in;
    assign borrow_out = (~rem_in & den_reg) | (~(rem_in ^ den_reg) & borrow_in);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg <= 1'b0;
            quo_reg <= num_bit;
            den_reg <= den_bit;
        end else if (ctrl.step) begin
            rem_reg <= take ? diff : rem_in;
            quo_reg <= quo_in;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

`default_nettype wire

/* hw/rtl/ud64_cell_row.sv */
// row of divider cells chained by shift and borrow
`default_nettype none

module ud64_cell_row
    import ud64_pkg::*;
(
    input  wire logic                  aclk,
    input  wire row_ctrl_t             ctrl,
    input  wire logic [DATA_WIDTH-1:0] num,
    input  wire logic [DATA_WIDTH-1:0] den,
    output logic      [DATA_WIDTH-1:0] quotient
);

    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH-1:0] borrow;
    logic [DATA_WIDTH-1:0] rem_in;
    logic [DATA_WIDTH-1:0] quo_in;
    logic [DATA_WIDTH-1:0] borrow_in;
    logic                  take;

    // the bit shifted out of the remainder means it is certainly >= divisor
    assign take = rem[DATA_WIDTH-1] | ~borrow[DATA_WIDTH-1];

    // dividend bits leave at the top and feed the remainder at the bottom
    assign rem_in    = {rem[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};
    assign quo_in    = {quo[DATA_WIDTH-2:0], take};
    assign borrow_in = {borrow[DATA_WIDTH-2:0], 1'b0};

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        ud64_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .num_bit    (num[i]),
            .den_bit    (den[i]),
            .rem_in     (rem_in[i]),
            .quo_in     (quo_in[i]),
            .borrow_in  (borrow_in[i]),
            .take       (take),
            .rem_out    (rem[i]),
            .quo_out    (quo[i]),
            .borrow_out (borrow[i])
        );
    end

    assign quotient = quo;

endmodule

`default_nettype wire

/* hw/rtl/unsigned_divider_64.sv */
// unsigned divider top level: stream ports, step controller and result register
// an accepted item steps the row in ST_RUN; ST_HOLD loads the output register
// and m_tvalid once it is free; one item at a time, one quotient bit per cycle
// from the row of cells whose borrow ripples through all DATA_WIDTH slices
// a finished item waits in the output register while the next one runs
// reset: synchronous active-low aresetn clears the controller and m_tvalid
`default_nettype none

module unsigned_divider_64
    import ud64_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2*FIELD_W-1:0] s_tdata,  // dividend, divisor
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [FIELD_W-1:0]   m_tdata,  // quotient
    output logic                      m_tuser   // divide_by_zero
);

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  dz_reg, dz_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [FIELD_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;
    logic [DATA_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH-1:0] quotient;
    logic                  out_free;
    row_ctrl_t             ctrl;

    assign num = s_tdata[DATA_WIDTH-1:0];
    assign den = s_tdata[FIELD_W +: DATA_WIDTH];

    // no item is taken while reset is held
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign ctrl.load = s_tvalid && s_tready;
    assign ctrl.step = (state_reg == ST_RUN);
    assign out_free  = !m_tvalid_reg || m_tready;

    ud64_cell_row u_row (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .num      (num),
        .den      (den),
        .quotient (quotient)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dz_next       = dz_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (ctrl.load) begin
                    dz_next    = (den == '0);
                    count_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                count_next = count_reg + 1'b1;
                if (count_reg == LAST_STEP) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = dz_reg ? '0 : FIELD_W'(quotient);
                    m_tuser_next  = dz_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        dz_reg      <= dz_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* hw/rtl/ud64_checker.sv */
// port-level checks on the unsigned divider, bound to the top level
`default_nettype none

module ud64_checker
    import ud64_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [FIELD_W-1:0]   m_tdata,
    input wire logic                 m_tuser
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // division by zero always reports a zero quotient
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("nonzero quotient with divide by zero");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a division runs");

    // a result cannot appear the cycle after its item was accepted
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind unsigned_divider_64 ud64_checker u_ud64_checker (.*);

`default_nettype wire

/* sim/unsigned_divider_64_tb.sv */
// self-checking testbench for the 64-bit unsigned divider stream block
`default_nettype none

module unsigned_divider_64_tb;
    import ud64_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FIELD_W-1:0] OPERAND_MASK = {FIELD_W{1'b1}} >> (FIELD_W - DATA_WIDTH);
    localparam logic [FIELD_W-1:0] ALL_ONES     = {FIELD_W{1'b1}};
    localparam logic [FIELD_W-1:0] TOP_BIT      = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam int                 TAIL_CYCLES  = DATA_WIDTH + 16;
    localparam int                 MAX_REPORTS  = 40;

    typedef struct {
        logic [FIELD_W-1:0] quotient;
        logic               div_by_zero;
    } quotient_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [2*FIELD_W-1:0] s_tdata  = '0;  // dividend, divisor
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [FIELD_W-1:0]   m_tdata;        // quotient
    logic                 m_tuser;        // divide_by_zero

    quotient_t pending_quotients[$];
    int        fail_count      = 0;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    int        hold_request    = 0;
    int        hold_left       = 0;

    unsigned_divider_64 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // truncated quotient of the low DATA_WIDTH bits, zero and flag on a zero divisor
    function automatic quotient_t divide_operands(logic [FIELD_W-1:0] dividend,
                                                  logic [FIELD_W-1:0] divisor);
        quotient_t          res;
        logic [FIELD_W-1:0] num;
        logic [FIELD_W-1:0] den;
        num = dividend & OPERAND_MASK;
        den = divisor & OPERAND_MASK;
        if (den == '0) begin
            res.quotient    = '0;
            res.div_by_zero = 1'b1;
        end else begin
            res.quotient    = (num / den) & OPERAND_MASK;
            res.div_by_zero = 1'b0;
        end
        return res;
    endfunction

    // random 64-bit value with a random magnitude
    function automatic logic [FIELD_W-1:0] random_operand();
        logic [FIELD_W-1:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, FIELD_W - 1);
    endfunction

    // receiver: random stalls, or a long hold-off counted down here
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker, values sampled as they stood before the edge
    always @(posedge aclk) begin
        quotient_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_quotients.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result quotient=%h div_by_zero=%b",
                             $time, m_tdata, m_tuser);
            end else begin
                want = pending_quotients.pop_front();
                if (m_tdata !== want.quotient) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: quotient mismatch expected=%h actual=%h",
                                 $time, want.quotient, m_tdata);
                end
                if (m_tuser !== want.div_by_zero) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: div_by_zero mismatch expected=%b actual=%b",
                                 $time, want.div_by_zero, m_tuser);
                end
            end
        end
    end

    // offer one item and return in the time step of its acceptance
    task automatic send_division(logic [FIELD_W-1:0] dividend, logic [FIELD_W-1:0] divisor);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {divisor, dividend};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_quotients.push_back(divide_operands(dividend, divisor));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_quotients.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        send_division(64'd0, 64'd0);
        send_division(ALL_ONES, 64'd0);
        send_division(64'd1, 64'd0);
        send_division(64'd0, 64'd1);
        send_division(ALL_ONES, 64'd1);
        send_division(ALL_ONES, ALL_ONES);
        send_division(ALL_ONES - 1, ALL_ONES);
        send_division(64'd1, ALL_ONES);
        send_division(64'd0, ALL_ONES);
        send_division(ALL_ONES, 64'd2);
        send_division(ALL_ONES, 64'd3);
        send_division(TOP_BIT, 64'd1);
        send_division(TOP_BIT, TOP_BIT);
        send_division(TOP_BIT - 1, TOP_BIT);
        send_division(ALL_ONES, TOP_BIT + 1);
        send_division(ALL_ONES, 64'h0000_0001_0000_0000);
        send_division(64'h0000_0001_0000_0000, 64'h0000_0000_ffff_ffff);
        send_division(64'h0000_0000_ffff_ffff, 64'd1);
        send_division(64'd5, 64'd7);
        send_division(64'd7, 64'd7);
        send_division(64'd100, 64'd7);
        send_division(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_division(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        wait_results_drained();
    endtask

    task automatic test_random_divisions(int count);
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
        int                 pick;
        for (int i = 0; i < count; i++) begin
            pick     = $urandom_range(99);
            dividend = {$urandom, $urandom};
            if (pick < 4) begin
                divisor = '0;
            end else if (pick < 20) begin
                divisor = 64'($urandom_range(1, 255));
            end else if (pick < 35) begin
                // divisor above the dividend gives a zero quotient
                divisor  = {$urandom, $urandom} | TOP_BIT;
                dividend = divisor - 64'($urandom_range(1, 1000)) - random_operand();
                if (dividend >= divisor) dividend = divisor - 1;
            end else if (pick < 50) begin
                dividend = {32'd0, $urandom};
                divisor  = {32'd0, $urandom} >> $urandom_range(0, 31);
            end else if (pick < 60) begin
                divisor = {$urandom, $urandom};
            end else begin
                dividend = random_operand();
                divisor  = random_operand();
            end
            send_division(dividend, divisor);
        end
    endtask

    // long receiver hold-off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_results_drained();
        hold_request = 400;
        for (int i = 0; i < 12; i++)
            send_division({$urandom, $urandom}, random_operand());
        wait_results_drained();
    endtask

    // sender stops until everything is back, then resumes
    task automatic test_sender_pause();
        for (int i = 0; i < 5; i++)
            send_division({$urandom, $urandom}, random_operand());
        wait_results_drained();
        repeat (10) @(posedge aclk);
        for (int i = 0; i < 5; i++)
            send_division({$urandom, $urandom}, random_operand());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_divisions(320);
        send_idle_pct  = 54;
        recv_stall_pct = 0;
        test_random_divisions(320);
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        test_random_divisions(320);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        test_random_divisions(320);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_output_backpressure();
        test_sender_pause();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_quotients.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
